// ----- sv/bbt_pkg.sv -----
// Shared types, constants and register codes of the block byte transform.
`timescale 1ns / 1ps
`default_nettype none

package bbt_pkg;

	localparam int KEY_BYTES   = 8;
	localparam int CFG_DATA_W  = 8 * KEY_BYTES;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_W       = 9;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_FROM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_TO   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_STEP = 3'd5;

	localparam logic [3:0] MODE_XOR   = 4'd0;
	localparam logic [3:0] MODE_ADD   = 4'd1;
	localparam logic [3:0] MODE_SUB   = 4'd2;
	localparam logic [3:0] MODE_MUL   = 4'd3;
	localparam logic [3:0] MODE_WRITE = 4'd4;
	localparam logic [3:0] MODE_DIV   = 4'd5;
	localparam logic [3:0] MODE_SHR   = 4'd6;
	localparam logic [3:0] MODE_SHL   = 4'd7;
	localparam logic [3:0] MODE_OR    = 4'd8;
	localparam logic [3:0] MODE_AND   = 4'd9;
	localparam logic [3:0] MODE_SWAP2 = 4'd10;
	localparam logic [3:0] MODE_SWAP4 = 4'd11;
	localparam logic [3:0] MODE_SEQ   = 4'd12;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_KEY,
		TAIL_SEQ
	} tail_t;

	typedef struct packed {
		logic [3:0]                mode;
		logic [CFG_DATA_W-1:0]     key_word;
		logic [3:0]                key_length;
		logic [7:0]                sequence_from;
		logic [7:0]                sequence_to;
		logic [7:0]                sequence_step;
	} cfg_t;

	typedef struct packed {
		logic [3:0][7:0] raw;
		logic [2:0]      nraw;
		tail_t           tail;
		logic [3:0]      op;
		logic [7:0]      data;
		logic [7:0]      key;
		logic            last;
	} cmd_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/bbt_if.sv -----
// Valid/ready channel interfaces for input bytes and result bytes.
`timescale 1ns / 1ps
`default_nettype none

interface bbt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       block_end;

	modport source(output valid, output data_in, output block_end, input ready);
	modport sink(input valid, input data_in, input block_end, output ready);
endinterface

interface bbt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       out_last;

	modport source(output valid, output data_out, output out_last, input ready);
	modport sink(input valid, input data_out, input out_last, output ready);
endinterface

`default_nettype wire

// ----- sv/bbt_front.sv -----
// Front end: accepts bytes, groups swap bytes and issues commands to the queue.
`timescale 1ns / 1ps
`default_nettype none

module bbt_front (
	input  logic          clk,
	input  logic          arst_n,
	bbt_in_if.sink        in_ch,
	input  bbt_pkg::cfg_t cfg,
	input  logic          full,
	output logic          push,
	output bbt_pkg::cmd_t cmd
);
	import bbt_pkg::*;

	logic [7:0] group_q [3];
	logic [1:0] fill_q;
	logic [2:0] key_pos_q;

	logic       accept;
	logic [2:0] gsize;
	logic       swap;
	logic       flush;
	logic [1:0] fill_eff;
	logic       complete;
	logic       store;
	logic [3:0] key_len;
	logic [3:0] pos_inc;
	logic [2:0] pos_next;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && !full;

	always_comb begin
		case (cfg.mode)
			MODE_SWAP2: gsize = 3'd2;
			MODE_SWAP4: gsize = 3'd4;
			default:    gsize = 3'd0;
		endcase
		swap     = (gsize != 3'd0);
		flush    = (fill_q != 2'd0) && (!swap || ({1'b0, fill_q} >= gsize));
		fill_eff = flush ? 2'd0 : fill_q;
		complete = swap && (({1'b0, fill_eff} + 3'd1) == gsize);
		store    = swap && !complete && !in_ch.block_end;

		if (cfg.key_length == 4'd0) begin
			key_len = 4'd1;
		end else if (cfg.key_length > 4'(KEY_BYTES)) begin
			key_len = 4'(KEY_BYTES);
		end else begin
			key_len = cfg.key_length;
		end
		pos_inc  = {1'b0, key_pos_q} + 4'd1;
		pos_next = (pos_inc >= key_len) ? 3'd0 : pos_inc[2:0];
	end

	always_comb begin
		cmd.raw[0]      = group_q[0];
		cmd.raw[1]      = group_q[1];
		cmd.raw[2]      = group_q[2];
		cmd.raw[3]      = in_ch.data_in;
		cmd.raw[fill_q] = in_ch.data_in;
		cmd.op          = cfg.mode;
		cmd.data        = in_ch.data_in;
		cmd.key         = cfg.key_word[8 * key_pos_q +: 8];
		cmd.last        = in_ch.block_end;
		cmd.tail        = TAIL_NONE;
		cmd.nraw        = flush ? {1'b0, fill_q} : 3'd0;

		if (swap) begin
			if (complete) begin
				cmd.nraw = gsize;
				if (gsize == 3'd2) begin
					cmd.raw[0] = in_ch.data_in;
					cmd.raw[1] = group_q[0];
				end else begin
					cmd.raw[0] = in_ch.data_in;
					cmd.raw[1] = group_q[2];
					cmd.raw[2] = group_q[1];
					cmd.raw[3] = group_q[0];
				end
			end else if (in_ch.block_end) begin
				cmd.nraw = {1'b0, fill_q} + 3'd1;
			end
		end else if (cfg.mode == MODE_SEQ) begin
			cmd.tail = TAIL_SEQ;
		end else begin
			cmd.tail = TAIL_KEY;
		end

		push = accept && ((cmd.nraw != 3'd0) || (cmd.tail != TAIL_NONE));
	end

	always_ff @(posedge clk) begin
		if (accept && store) begin
			group_q[fill_eff] <= in_ch.data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 2'd0;
			key_pos_q <= 3'd0;
		end else if (accept) begin
			fill_q <= store ? (fill_eff + 2'd1) : 2'd0;
			if (in_ch.block_end) begin
				key_pos_q <= 3'd0;
			end else if (cfg.mode <= MODE_AND) begin
				key_pos_q <= pos_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/bbt_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bbt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bbt_pkg::cmd_t push_cmd,
	input  logic          pop,
	output bbt_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import bbt_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/bbt_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by divide and sequence work.
`timescale 1ns / 1ps
`default_nettype none

module bbt_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  bbt_pkg::div_req_t req,
	output bbt_pkg::div_rsp_t rsp
);
	import bbt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       trial;
	logic                 fits;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign fits     = (trial >= {1'b0, dvs_q});
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= fits ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/bbt_back.sv -----
// Back end: executes queued commands and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module bbt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bbt_pkg::cfg_t     cfg,
	input  bbt_pkg::cmd_t     head,
	input  logic              empty,
	output logic              pop,
	output bbt_pkg::div_req_t div_req,
	input  bbt_pkg::div_rsp_t div_rsp,
	bbt_out_if.source         out_ch
);
	import bbt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_DIV,
		ST_SEQ1,
		ST_SEQ2,
		ST_EMIT
	} state_t;

	state_t     state_q;
	cmd_t       cmd_q;
	logic [2:0] idx_q;
	logic [7:0] res_q;
	logic [7:0] seq_value_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	logic             can_load;
	logic             raw_done;
	logic             key_div;
	logic [7:0]       key_res;
	logic [7:0]       seq_to;
	logic [7:0]       seq_step;
	logic [DIV_W-1:0] dif;

	function automatic logic [7:0] key_op(input logic [3:0] op, input logic [7:0] d,
		input logic [7:0] k);
		logic [15:0] prod;
		logic [7:0]  r;
		prod = 16'(d) * 16'(k);
		case (op)
			MODE_XOR:   r = d ^ k;
			MODE_ADD:   r = d + k;
			MODE_SUB:   r = d - k;
			MODE_MUL:   r = prod[7:0];
			MODE_WRITE: r = k;
			MODE_DIV:   r = 8'd0;
			MODE_SHR:   r = (k >= 8'd8) ? 8'd0 : (d >> k[2:0]);
			MODE_SHL:   r = (k >= 8'd8) ? 8'd0 : (d << k[2:0]);
			MODE_OR:    r = d | k;
			MODE_AND:   r = d & k;
			default:    r = d;
		endcase
		return r;
	endfunction

	assign can_load        = !out_valid_q || out_ch.ready;
	assign raw_done        = (idx_q == cmd_q.nraw);
	assign key_div         = (cmd_q.op == MODE_DIV) && (cmd_q.key != 8'd0);
	assign key_res         = key_op(cmd_q.op, cmd_q.data, cmd_q.key);
	assign pop             = (state_q == ST_IDLE) && !empty;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.data_out = out_data_q;
	assign out_ch.out_last = out_last_q;

	always_comb begin
		seq_to   = (cfg.sequence_to == 8'd0) ? 8'd255 : cfg.sequence_to;
		seq_step = (cfg.sequence_step == 8'd0) ? 8'd1 : cfg.sequence_step;
		if (seq_to <= cfg.sequence_from) begin
			dif = DIV_W'(255);
		end else begin
			dif = DIV_W'(seq_to) - DIV_W'(cfg.sequence_from) + DIV_W'(1);
		end
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(cmd_q.data);
		div_req.divisor  = DIV_W'(cmd_q.key);
		case (state_q)
			ST_RAW: begin
				if (raw_done && cmd_q.tail == TAIL_KEY && key_div) begin
					div_req.start = 1'b1;
				end else if (raw_done && cmd_q.tail == TAIL_SEQ) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(seq_value_q);
					div_req.divisor  = dif;
				end
			end
			ST_SEQ1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = DIV_W'(div_rsp.rem[7:0]) + DIV_W'(seq_step);
				div_req.divisor  = dif;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			idx_q       <= 3'd0;
			res_q       <= 8'd0;
			seq_value_q <= 8'd0;
			out_valid_q <= 1'b0;
			out_data_q  <= 8'd0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						cmd_q   <= head;
						idx_q   <= 3'd0;
						state_q <= ST_RAW;
					end
				end
				ST_RAW: begin
					if (!raw_done) begin
						if (can_load) begin
							out_valid_q <= 1'b1;
							out_data_q  <= cmd_q.raw[idx_q[1:0]];
							out_last_q  <= cmd_q.last && (cmd_q.tail == TAIL_NONE) &&
								((idx_q + 3'd1) == cmd_q.nraw);
							idx_q       <= idx_q + 3'd1;
						end
					end else begin
						case (cmd_q.tail)
							TAIL_KEY: begin
								if (key_div) begin
									state_q <= ST_DIV;
								end else begin
									res_q   <= key_res;
									state_q <= ST_EMIT;
								end
							end
							TAIL_SEQ: begin
								state_q <= ST_SEQ1;
							end
							default: begin
								if (cmd_q.last) begin
									seq_value_q <= 8'd0;
								end
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						res_q   <= div_rsp.quo[7:0];
						state_q <= ST_EMIT;
					end
				end
				ST_SEQ1: begin
					if (div_rsp.done) begin
						res_q   <= div_rsp.rem[7:0] + cfg.sequence_from;
						state_q <= ST_SEQ2;
					end
				end
				ST_SEQ2: begin
					if (div_rsp.done) begin
						seq_value_q <= div_rsp.rem[7:0];
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						out_last_q  <= cmd_q.last;
						if (cmd_q.last) begin
							seq_value_q <= 8'd0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/block_byte_transform.sv -----
// Top level of the block byte transform: configuration registers and submodule wiring.
// Bytes of a block enter on in_ch (valid/ready), the final byte flagged by block_end.
// Result bytes leave on out_ch (valid/ready); out_last flags the final result of a block.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write
// them only while the block is idle, as the block itself does not enforce it. A front
// end classifies each item and places a command in a two-entry queue; a back end runs
// the commands one at a time and holds each result byte in an output register. An item
// is accepted whenever the queue has room, so input keeps flowing while the output
// register waits. Swap modes hold bytes until a group is complete. For plain key modes
// an accepted byte passes the queue, the command register and the result register on
// its way to the output register. A divide waits on the shared restoring divider, and a
// sequence byte needs two divider runs.
// A stalled receiver holds the output register and then the queue; input stops once
// the queue is full. Reset clears the queue, the output register, the key position,
// the sequence counter and the swap group fill, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module block_byte_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	bbt_in_if.sink                              in_ch,
	bbt_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  logic [bbt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bbt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bbt_pkg::*;

	cfg_t     cfg_q;
	cmd_t     push_cmd;
	cmd_t     head;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= MODE_XOR;
			cfg_q.key_word      <= '0;
			cfg_q.key_length    <= 4'd1;
			cfg_q.sequence_from <= 8'd0;
			cfg_q.sequence_to   <= 8'd255;
			cfg_q.sequence_step <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:          cfg_q.mode          <= cfg_data[3:0];
				REG_KEY_WORD:      cfg_q.key_word      <= cfg_data;
				REG_KEY_LENGTH:    cfg_q.key_length    <= cfg_data[3:0];
				REG_SEQUENCE_FROM: cfg_q.sequence_from <= cfg_data[7:0];
				REG_SEQUENCE_TO:   cfg_q.sequence_to   <= cfg_data[7:0];
				REG_SEQUENCE_STEP: cfg_q.sequence_step <= cfg_data[7:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	bbt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	bbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	bbt_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bbt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire
